>>> rtl/bit_line_packer_macros.svh
// Assertion macros used by the bit line packer checker.
`ifndef BIT_LINE_PACKER_MACROS_SVH
`define BIT_LINE_PACKER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit_line_packer: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit_line_packer: next-cycle check failed");

`endif

>>> rtl/blp_pkg.sv
// Types and constants shared by the bit line packer modules.
package blp_pkg;

    // Default store size in bytes.
    localparam int STORE_BYTES_DEF = 512;

    // Fill patterns for whole bytes of a run.
    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    // Operation codes carried in the op field.
    typedef enum logic [2:0] {
        OP_RESET_POS    = 3'd0,
        OP_APPEND_ONES  = 3'd1,
        OP_APPEND_ZEROS = 3'd2,
        OP_APPEND_BYTE  = 3'd3,
        OP_SET_BYTE     = 3'd4,
        OP_READ_BYTE    = 3'd5
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD,
        S_BYTE2,
        S_FILL,
        S_READ,
        S_RESP
    } t_state;

    // Input transaction payload.
    typedef struct packed {
        logic [2:0]  op;
        logic [12:0] run_length;
        logic [7:0]  data_byte;
        logic [8:0]  byte_index;
    } t_in;

    // Result transaction payload.
    typedef struct packed {
        logic        status;
        logic [12:0] bit_position;
        logic [7:0]  read_data;
    } t_out;

endpackage

>>> rtl/bit_line_packer.sv
// Bit line packer: appends bit runs and bytes MSB-first into a byte line store, with byte
// set and read access. One transaction is handled at a time by a sequencer around a
// single-port-write, single-port-read store with a registered read port. Every transaction
// passes through decode and a result state; an in-range read byte adds a read state, an
// unaligned append byte adds head and second-byte states, and a nonzero run of ones or zeros
// adds a head state and, when it crosses a byte boundary, a fill state, since the store takes
// one byte write per cycle. Rejected appends go from decode straight to the result state.
// The result register lets a new transaction be accepted while a result waits.
// The store is not cleared at reset; bytes never written read back as undefined.
module bit_line_packer #(
    parameter int STORE_BYTES = blp_pkg::STORE_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  blp_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output blp_pkg::t_out o_out
);

    import blp_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // Sequencer and result register.
    blp_ctrl #(
        .STORE_BYTES (STORE_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Line store.
    blp_ram #(
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

>>> rtl/blp_ram.sv
// Byte-wide line store: one write port and one registered read port.
module blp_ram #(
    parameter int   DEPTH = blp_pkg::STORE_BYTES_DEF,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/blp_ctrl.sv
// Sequencer for the bit line packer: decode, read-modify-write of the store, result register.
module blp_ctrl #(
    parameter int  STORE_BYTES = blp_pkg::STORE_BYTES_DEF,
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  blp_pkg::t_in     i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output blp_pkg::t_out    o_out,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output logic [7:0]       o_mem_wdata,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_raddr,
    input  logic [7:0]       i_mem_rdata
);

    import blp_pkg::*;

    // Capacity in bits and the widths that follow from it.
    localparam int CAP = STORE_BYTES * 8;
    localparam int PW  = $clog2(CAP + 1);
    localparam int BW  = PW - 3;
    localparam int EW  = ((PW > 13) ? PW : 13) + 1;

    t_state          r_state, n_state;
    t_in             r_req, n_req;
    logic [PW-1:0]   r_pos, n_pos;
    logic [PW-1:0]   r_end, n_end;
    logic [BW-1:0]   r_addr, n_addr;
    logic            r_status, n_status;
    logic [7:0]      r_rd, n_rd;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    logic [EW-1:0]   add_len;
    logic [EW-1:0]   sum;
    logic            over;
    logic            idx_ok;
    logic [2:0]      k;
    logic [2:0]      ke;
    logic [BW-1:0]   sb;
    logic [BW-1:0]   eb;
    logic            run_val;
    logic [7:0]      fill;
    logic [7:0]      head_mask;

    // Position arithmetic shared by the states.
    always_comb begin
        add_len   = (r_req.op == OP_APPEND_BYTE) ? EW'(8) : EW'(r_req.run_length);
        sum       = EW'(r_pos) + add_len;
        over      = sum > EW'(CAP);
        idx_ok    = 32'(r_req.byte_index) < 32'(STORE_BYTES);
        k         = r_pos[2:0];
        ke        = r_end[2:0];
        sb        = r_pos[PW-1:3];
        eb        = r_end[PW-1:3];
        run_val   = (r_req.op == OP_APPEND_ONES);
        fill      = run_val ? BYTE_ONES : BYTE_ZEROS;
        head_mask = (8'hFF >> k) & ((eb == sb) ? ~(8'hFF >> ke) : 8'hFF);
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_end    <= n_end;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_out    <= n_out;
    end

    // Next state, store accesses and result loading.
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_pos       = r_pos;
        n_end       = r_end;
        n_addr      = r_addr;
        n_status    = r_status;
        n_rd        = r_rd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_in_ready  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(sb);
        o_mem_wdata = BYTE_ZEROS;
        o_mem_re    = 1'b0;
        o_mem_raddr = AW'(sb);

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_status = 1'b0;
                n_rd     = 8'd0;
                n_end    = sum[PW-1:0];
                n_state  = S_RESP;
                unique case (r_req.op)
                    OP_RESET_POS: begin
                        n_pos = '0;
                    end
                    OP_APPEND_ONES, OP_APPEND_ZEROS: begin
                        if (over) begin
                            n_status = 1'b1;
                        end else if (r_req.run_length != 13'd0) begin
                            // Fetch the byte that holds the start of the run.
                            o_mem_re = 1'b1;
                            n_state  = S_HEAD;
                        end
                    end
                    OP_APPEND_BYTE: begin
                        if (over) begin
                            n_status = 1'b1;
                        end else if (k == 3'd0) begin
                            // Aligned byte overwrites a whole entry.
                            o_mem_we    = 1'b1;
                            o_mem_wdata = r_req.data_byte;
                            n_pos       = sum[PW-1:0];
                        end else begin
                            o_mem_re = 1'b1;
                            n_state  = S_HEAD;
                        end
                    end
                    OP_SET_BYTE: begin
                        if (idx_ok) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_req.byte_index);
                            o_mem_wdata = r_req.data_byte;
                        end else begin
                            n_status = 1'b1;
                        end
                    end
                    OP_READ_BYTE: begin
                        if (idx_ok) begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = AW'(r_req.byte_index);
                            n_state     = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end

            S_HEAD: begin
                // Merge new bits into the first byte; read data is for entry sb.
                o_mem_we = 1'b1;
                n_addr   = sb + BW'(1);
                if (r_req.op == OP_APPEND_BYTE) begin
                    o_mem_wdata = (i_mem_rdata & ~(8'hFF >> k)) | (r_req.data_byte >> k);
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(sb + BW'(1));
                    n_state     = S_BYTE2;
                end else begin
                    o_mem_wdata = run_val ? (i_mem_rdata | head_mask)
                                          : (i_mem_rdata & ~head_mask);
                    if (eb == sb) begin
                        n_pos   = r_end;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_FILL;
                    end
                end
            end

            S_BYTE2: begin
                // Low bits of the appended byte go to the top of the next entry.
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_addr);
                o_mem_wdata = (i_mem_rdata & (8'hFF >> k))
                            | 8'(r_req.data_byte << (4'd8 - {1'b0, k}));
                n_pos       = r_end;
                n_state     = S_RESP;
            end

            S_FILL: begin
                o_mem_waddr = AW'(r_addr);
                if (r_addr != eb) begin
                    // Whole bytes of the run, one per cycle.
                    o_mem_we    = 1'b1;
                    o_mem_wdata = fill;
                    n_addr      = r_addr + BW'(1);
                end else begin
                    // Byte at the new position: run bits, rest cleared.
                    o_mem_we    = 32'(eb) < 32'(STORE_BYTES);
                    o_mem_wdata = run_val ? ~(8'hFF >> ke) : BYTE_ZEROS;
                    n_pos       = r_end;
                    n_state     = S_RESP;
                end
            end

            S_READ: begin
                n_rd    = i_mem_rdata;
                n_state = S_RESP;
            end

            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_status;
                    n_out.bit_position = 13'(r_pos);
                    n_out.read_data    = r_rd;
                    n_state            = S_IDLE;
                end
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/blp_checker.sv
// Port-level checker for the bit line packer and its bind to the top level.
`include "bit_line_packer_macros.svh"

module blp_checker #(
    parameter int STORE_BYTES = blp_pkg::STORE_BYTES_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input blp_pkg::t_out o_out
);

    import blp_pkg::*;

    localparam int   CAP       = STORE_BYTES * 8;
    localparam logic CAP_FITS  = (CAP < 8192);

    // Only one transaction is in flight: an accept closes the input side.
    `BLP_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // A rejected transaction never returns read data.
    `BLP_ASSERT_NOW(a_reject_no_data, i_clk, i_rst_n, o_out_valid && o_out.status, o_out.read_data == 8'd0)

    // The reported position never passes the end of the store.
    `BLP_ASSERT_NOW(a_pos_in_store, i_clk, i_rst_n, o_out_valid && CAP_FITS, 32'(o_out.bit_position) <= 32'(CAP))

    // A stalled result stays valid and unchanged.
    `BLP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))

endmodule

bind bit_line_packer blp_checker #(.STORE_BYTES(STORE_BYTES)) u_blp_checker (.*);
